/* src/psba_pkg.sv */
// shared constants and types for the page slot bitmap allocator
// no dependencies; used by psba_ffz and page_slot_bitmap_allocator
package psba_pkg;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int WORD_BITS      = 32;
	localparam int BIT_IDX_W      = 5;
	localparam int PAGE_SHIFT     = 12;
	localparam int ADDR_W         = 32;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

endpackage

/* src/page_slot_bitmap_allocator.sv */
// top level of the page slot bitmap allocator: bitmap memory, control fsm, result register
// depends on psba_pkg and psba_ffz
//
// usage:
//   a transaction is taken at a clock edge with start high and busy low.
//   func 0 allocates the lowest free slot and answers page_base + slot * 4096,
//   func 1 frees the slot that address falls in.
//   every transaction gives one result on page_address/status, shown for one
//   cycle with done high; the receiver cannot stall, so no result is held.
//   the user writes page_base (cfg_we/cfg_wdata) only while idle; the block doesn't check.
// timing:
//   the bitmap is a one-port-read, one-port-write memory of WORD_COUNT words
//   (SLOT_COUNT/32 rounded up) with registered read data. an allocate reads
//   one word per cycle and the search stops at the first word with a free
//   bit, or after the last word when the bitmap is full. a free takes one
//   read-modify-write; an out-of-range address is answered without a read.
//   busy is high while a read is outstanding.
// reset:
//   arst_n clears page_base and marks every word invalid, so every slot reads
//   free at once; no clearing pass is needed.
module page_slot_bitmap_allocator import psba_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [ADDR_W-1:0] address,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	output logic              done,
	output logic [ADDR_W-1:0] page_address,
	output logic [1:0]        status
);

	localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SLOT_HI_W  = ADDR_W - PAGE_SHIFT;
	localparam int PAD_BITS   = WORD_COUNT * WORD_BITS - SLOT_COUNT;
	localparam logic [WORD_BITS-1:0] LAST_PAD =
		(PAD_BITS == 0) ? '0 : ~({WORD_BITS{1'b1}} >> PAD_BITS);
	localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORD_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ASCAN = 3'b010,
		S_FCHK  = 3'b100
	} state_t;

	state_t                 state_q, state_d;
	logic [ADDR_W-1:0]      page_base_q;
	logic [WIDX-1:0]        chk_idx_q, chk_idx_d;
	logic [BIT_IDX_W-1:0]   bit_q, bit_d;
	logic [WORD_COUNT-1:0]  valid_q;

	logic [WORD_BITS-1:0]   mem [WORD_COUNT];
	logic [WORD_BITS-1:0]   rdata_s1;
	logic                   rvalid_s1;

	logic                   rd_en, wr_en;
	logic [WIDX-1:0]        rd_addr, wr_addr;
	logic [WORD_BITS-1:0]   wr_data;

	logic                   done_q, done_d;
	logic [ADDR_W-1:0]      page_address_q, page_address_d;
	status_t                status_q, status_d;

	logic [ADDR_W-1:0]      diff;
	logic [SLOT_HI_W-1:0]   slot_hi;
	logic                   in_range;
	logic [WORD_BITS-1:0]   word_s1, scan_word;
	logic                   ffz_found;
	logic [BIT_IDX_W-1:0]   ffz_idx;
	logic [WORD_BITS-1:0]   ffz_onehot;

	// free address to slot, wrapping modulo 2^32
	assign diff     = address - page_base_q;
	assign slot_hi  = diff[ADDR_W-1:PAGE_SHIFT];
	assign in_range = slot_hi < SLOT_HI_W'(SLOT_COUNT);

	// never-written words read as all free
	assign word_s1   = rvalid_s1 ? rdata_s1 : '0;
	// slots past SLOT_COUNT in the last word look used to the search
	assign scan_word = word_s1 | ((chk_idx_q == LAST_WORD) ? LAST_PAD : '0);

	psba_ffz u_ffz (
		.word   (scan_word),
		.found  (ffz_found),
		.idx    (ffz_idx),
		.onehot (ffz_onehot)
	);

	always_comb begin
		state_d        = state_q;
		chk_idx_d      = chk_idx_q;
		bit_d          = bit_q;
		rd_en          = 1'b0;
		rd_addr        = chk_idx_q + WIDX'(1);
		wr_en          = 1'b0;
		wr_addr        = chk_idx_q;
		wr_data        = word_s1 | ffz_onehot;
		done_d         = 1'b0;
		page_address_d = '0;
		status_d       = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!func) begin
						rd_en     = 1'b1;
						rd_addr   = '0;
						chk_idx_d = '0;
						state_d   = S_ASCAN;
					end else if (in_range) begin
						rd_en     = 1'b1;
						rd_addr   = slot_hi[WIDX+BIT_IDX_W-1:BIT_IDX_W];
						chk_idx_d = slot_hi[WIDX+BIT_IDX_W-1:BIT_IDX_W];
						bit_d     = slot_hi[BIT_IDX_W-1:0];
						state_d   = S_FCHK;
					end else begin
						done_d   = 1'b1;
						status_d = ST_BAD_FREE;
					end
				end
			end
			S_ASCAN: begin
				if (ffz_found) begin
					wr_en          = 1'b1;
					done_d         = 1'b1;
					page_address_d = page_base_q +
						(ADDR_W'({chk_idx_q, ffz_idx}) << PAGE_SHIFT);
					state_d        = S_IDLE;
				end else if (chk_idx_q == LAST_WORD) begin
					done_d   = 1'b1;
					status_d = ST_FULL;
					state_d  = S_IDLE;
				end else begin
					// next word read goes out while this one is checked
					rd_en     = 1'b1;
					chk_idx_d = chk_idx_q + WIDX'(1);
				end
			end
			S_FCHK: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
				if (word_s1[bit_q]) begin
					wr_en   = 1'b1;
					wr_data = word_s1 & ~(WORD_BITS'(1) << bit_q);
				end else begin
					status_d = ST_BAD_FREE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_base_q <= '0;
			valid_q     <= '0;
			done_q      <= 1'b0;
			chk_idx_q   <= '0;
			bit_q       <= '0;
		end else begin
			state_q   <= state_d;
			done_q    <= done_d;
			chk_idx_q <= chk_idx_d;
			bit_q     <= bit_d;
			if (cfg_we) begin
				page_base_q <= cfg_wdata;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1  <= mem[rd_addr];
			rvalid_s1 <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (done_d) begin
			page_address_q <= page_address_d;
			status_q       <= status_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign page_address = page_address_q;
	assign status       = status_q;

`ifndef NO_ASSERTIONS
	// a result only appears once the fsm is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the bitmap is only written at the end of a transaction
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("bitmap write while idle");

	// a full or bad result never carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q != ST_OK)) |-> (page_address == '0))
		else $error("failed transaction with nonzero address");

	// the scan never runs past the last bitmap word
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ASCAN) |-> ({1'b0, chk_idx_q} < (WIDX+1)'(WORD_COUNT)))
		else $error("scan index past last word");
`endif

endmodule

/* src/psba_ffz.sv */
// lowest zero bit finder for one 32-bit bitmap word
// depends on psba_pkg for the word width
module psba_ffz import psba_pkg::*; (
	input  logic [WORD_BITS-1:0] word,
	output logic                 found,
	output logic [BIT_IDX_W-1:0] idx,
	output logic [WORD_BITS-1:0] onehot
);

	// isolate the lowest clear bit: ~w & (w + 1)
	assign onehot = ~word & (word + WORD_BITS'(1));
	assign found  = ~&word;

	always_comb begin
		idx = '0;
		for (int b = 0; b < BIT_IDX_W; b++) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				if (((i >> b) & 1) == 1) begin
					idx[b] = idx[b] | onehot[i];
				end
			end
		end
	end

endmodule

/* tb/testbench.sv */
// self-checking testbench for page_slot_bitmap_allocator: directed table, then random phases
// depends on psba_pkg and the allocator rtl; an internal slot map model predicts every untyped result
module testbench import psba_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = SLOT_COUNT_DEF;
	localparam int WORD_COUNT  = SLOTS / WORD_BITS;
	localparam int STALL_LIMIT = 2000;
	localparam int DIR_ROWS    = 21;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef enum logic {
		ROW_REQ,
		ROW_BASE
	} row_kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		status_t           status;
	} page_result_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              func;
		logic [ADDR_W-1:0] value;
		logic              typed;
		logic [ADDR_W-1:0] page_address;
		status_t           status;
	} dir_row_t;

	// typed rows hold values readable straight from the slot rules
	localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
		'{ROW_REQ,  FN_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_BAD_FREE},
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_1000, ST_OK},
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_2000, ST_OK},
		'{ROW_REQ,  FN_FREE,  32'h0000_1FFF, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_FREE,  32'h0000_1000, 1'b1, 32'h0000_0000, ST_BAD_FREE},
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_BAD_FREE},
		'{ROW_REQ,  FN_FREE,  32'h003F_F000, 1'b1, 32'h0000_0000, ST_BAD_FREE},
		'{ROW_REQ,  FN_FREE,  32'h0040_0000, 1'b1, 32'h0000_0000, ST_BAD_FREE},
		'{ROW_REQ,  FN_ALLOC, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_FREE,  32'h0000_0ABC, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_BASE, FN_ALLOC, 32'hFFFF_C000, 1'b0, 32'h0000_0000, ST_OK},
		// slot 4 wraps to address zero and still succeeds
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
		// below the base wraps to a huge slot number
		'{ROW_REQ,  FN_FREE,  32'hFFFF_B000, 1'b1, 32'h0000_0000, ST_BAD_FREE},
		'{ROW_REQ,  FN_FREE,  32'hFFFF_C123, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_BASE, FN_ALLOC, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_ALLOC, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ,  FN_FREE,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK}
	};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              func      = FN_ALLOC;
	logic [ADDR_W-1:0] address   = '0;
	logic              cfg_we    = 1'b0;
	logic [ADDR_W-1:0] cfg_wdata = '0;
	logic              busy;
	logic              done;
	logic [ADDR_W-1:0] page_address;
	logic [1:0]        status;

	logic [SLOTS-1:0]  slot_used_map = '0;
	logic [ADDR_W-1:0] base_model    = '0;
	int                slots_in_use  = 0;
	int                full_answers  = 0;
	int                error_count   = 0;
	int                result_index  = 0;
	int                idle_cycles   = 0;
	page_result_t      awaited_results [$];

	page_slot_bitmap_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.address      (address),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.page_address (page_address),
		.status       (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// slot map model: one used bit per slot, lowest free slot wins on allocate
	task automatic predict_request(input logic f, input logic [ADDR_W-1:0] a,
			output page_result_t res);
		int unsigned       slot;
		logic [ADDR_W-1:0] rel;
		bit                found;
		res.page_address = '0;
		res.status       = ST_OK;
		if (f == FN_ALLOC) begin
			found = 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				if (!found && !slot_used_map[s]) begin
					found = 1'b1;
					slot  = s;
				end
			end
			if (!found) begin
				res.status = ST_FULL;
				full_answers++;
			end else begin
				slot_used_map[slot] = 1'b1;
				slots_in_use++;
				res.page_address = base_model + (ADDR_W'(slot) << PAGE_SHIFT);
			end
		end else begin
			rel  = a - base_model;
			slot = rel >> PAGE_SHIFT;
			if (slot >= SLOTS) begin
				res.status = ST_BAD_FREE;
			end else if (!slot_used_map[slot]) begin
				res.status = ST_BAD_FREE;
			end else begin
				slot_used_map[slot] = 1'b0;
				slots_in_use--;
			end
		end
	endtask

	// drive one transaction, wait for acceptance, then record its expected result
	task automatic issue_request(input logic f, input logic [ADDR_W-1:0] a,
			input bit typed, input page_result_t typed_res);
		page_result_t predicted;
		start   <= 1'b1;
		func    <= f;
		address <= a;
		do @(posedge clk); while (busy);
		predict_request(f, a, predicted);
		awaited_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) begin
			func    <= logic'($urandom_range(0, 1));
			address <= $urandom;
			@(posedge clk);
		end
	endtask

	task automatic maybe_gap();
		if ($urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 6));
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_page_base(input logic [ADDR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		base_model  = value;
	endtask

	task automatic make_request(input int alloc_pct, output logic f,
			output logic [ADDR_W-1:0] a);
		int unsigned slot;
		f = ($urandom_range(0, 99) < alloc_pct) ? FN_ALLOC : FN_FREE;
		a = $urandom;
		if (f == FN_FREE) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// mostly hit a slot that is in use
					slot = $urandom_range(0, SLOTS - 1);
					if (slots_in_use > 0)
						while (!slot_used_map[slot])
							slot = (slot + 1) % SLOTS;
					a = base_model + (ADDR_W'(slot) << PAGE_SHIFT) + $urandom_range(0, 4095);
				end
				6: a = base_model + (ADDR_W'($urandom_range(0, SLOTS - 1)) << PAGE_SHIFT)
					+ $urandom_range(0, 4095);
				7: a = base_model + (ADDR_W'($urandom_range(SLOTS, 20'hFFFFF)) << PAGE_SHIFT)
					+ $urandom_range(0, 4095);
				8: a = $urandom;
				default: a = base_model - $urandom_range(1, 8192);
			endcase
		end
	endtask

	task automatic run_phase(input int n_items, input int alloc_pct, input bit with_gaps,
			input bit until_full);
		logic              f;
		logic [ADDR_W-1:0] a;
		int                i;
		int                full_mark;
		i         = 0;
		full_mark = full_answers;
		while (i < n_items || (until_full && full_answers - full_mark < 6)) begin
			make_request(alloc_pct, f, a);
			issue_request(f, a, 1'b0, '0);
			i++;
			if (with_gaps) begin
				if ($urandom_range(0, 49) == 0)
					wait_results_drained();
				else
					maybe_gap();
			end
		end
		wait_results_drained();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			page_result_t want;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result %0d with no request outstanding", result_index));
			end else begin
				want = awaited_results.pop_front();
				if (page_address !== want.page_address)
					report_mismatch($sformatf("result %0d page_address %h, want %h",
						result_index, page_address, want.page_address));
				if (status !== want.status)
					report_mismatch($sformatf("result %0d status %0d, want %0d",
						result_index, status, want.status));
			end
			result_index++;
		end
	end

	// no transaction of any kind for too long means the block hung
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIRECTED_ROWS[r].kind == ROW_BASE) begin
				wait_results_drained();
				set_page_base(DIRECTED_ROWS[r].value);
			end else begin
				issue_request(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].value,
					DIRECTED_ROWS[r].typed,
					'{DIRECTED_ROWS[r].page_address, DIRECTED_ROWS[r].status});
				maybe_gap();
			end
		end
		wait_results_drained();

		set_page_base(32'hFFFF_F000);
		run_phase(150, 60, 1'b1, 1'b0);
		// alloc heavy until the bitmap fills and answers full a few times
		set_page_base($urandom & 32'hFFFF_F000);
		run_phase(0, 92, 1'b1, 1'b1);
		set_page_base(32'hFFFF_FFFF);
		run_phase(200, 25, 1'b1, 1'b0);
		set_page_base(32'h0000_0000);
		run_phase(150, 50, 1'b1, 1'b0);
		set_page_base($urandom);
		run_phase(150, 50, 1'b0, 1'b0);

		repeat (WORD_COUNT + 8) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
